[hdl/poc_reorder_output_queue_macros.svh]
// ----------------------------------------------------------------------------
// Reorder output queue assertion macros
// Concurrent check wrappers on clock; PORQ_ASSERT is masked while reset is high, PORQ_ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef POC_REORDER_OUTPUT_QUEUE_MACROS_SVH
`define POC_REORDER_OUTPUT_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define PORQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define PORQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define PORQ_ASSERT(label, prop, msg)

`define PORQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[hdl/porq_pkg.sv]
// ----------------------------------------------------------------------------
// Reorder output queue package
// Item types, operation and outcome codes, controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package porq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int QUEUED_WIDTH        = 5;
   localparam int REORDER_WIDTH       = 5;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_BUMP  = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] OUT_DONE   = 2'd0;
   localparam logic [1:0] OUT_POPPED = 2'd1;
   localparam logic [1:0] OUT_FULL   = 2'd2;
   localparam logic [1:0] OUT_EMPTY  = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [31:0]        frame_handle;
      logic signed [31:0] order_count;
   } porq_req_type;

   typedef struct packed {
      logic [1:0]                outcome;
      logic [31:0]               popped_handle;
      logic signed [31:0]        popped_count;
      logic [QUEUED_WIDTH-1:0]   queued;
   } porq_rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       push;
      logic       clear;
      logic       scan_start;
      logic       scan;
      logic       shift_start;
      logic       shift;
      logic       load_rsp;
      logic [1:0] outcome;
   } porq_cmd_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       full;
      logic       empty;
      logic       over_limit;
      logic       scan_done;
      logic       shift_done;
   } porq_status_type;

endpackage

[hdl/porq_ctrl.sv]
// ----------------------------------------------------------------------------
// Reorder output queue controller
// Sequences decode, minimum scan, entry shift and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "poc_reorder_output_queue_macros.svh"

module porq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  porq_pkg::porq_status_type status,
   output porq_pkg::porq_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] outcome_ff, outcome_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.outcome  = outcome_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            case (status.operation)
               porq_pkg::OP_PUSH: begin
                  if (status.full) begin
                     outcome_in = porq_pkg::OUT_FULL;
                  end else begin
                     outcome_in = porq_pkg::OUT_DONE;
                     cmd.push   = 1'b1;
                  end
               end
               porq_pkg::OP_BUMP: begin
                  if (status.over_limit) begin
                     outcome_in     = porq_pkg::OUT_POPPED;
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end else begin
                     outcome_in = porq_pkg::OUT_DONE;
                  end
               end
               porq_pkg::OP_FLUSH: begin
                  if (status.empty) begin
                     outcome_in = porq_pkg::OUT_EMPTY;
                  end else begin
                     outcome_in     = porq_pkg::OUT_POPPED;
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  outcome_in = porq_pkg::OUT_DONE;
                  cmd.clear  = 1'b1;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         outcome_ff   <= porq_pkg::OUT_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         outcome_ff   <= outcome_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PORQ_ASSERT(a_load_no_overwrite, cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall), "result overwritten")
   `PORQ_ASSERT(a_accept_decodes, (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_DECODE, "accepted item not decoded")
   `PORQ_ASSERT(a_pop_scans, (state_ff == ST_FINISH && outcome_ff == porq_pkg::OUT_POPPED) |-> $past(state_ff) == ST_SHIFT || $past(state_ff) == ST_FINISH, "pop without scan")

endmodule

[hdl/porq_datapath.sv]
// ----------------------------------------------------------------------------
// Reorder output queue datapath
// Entry memory, fill level, minimum search, shift-down and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "poc_reorder_output_queue_macros.svh"

module porq_datapath #(
   parameter int QUEUE_DEPTH = porq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [porq_pkg::REORDER_WIDTH-1:0]    csr_data,
   input  porq_pkg::porq_req_type                req_payload,
   input  porq_pkg::porq_cmd_type                cmd,
   output porq_pkg::porq_status_type             status,
   output porq_pkg::porq_rsp_type                rsp_payload
);

   localparam int AW   = $clog2(QUEUE_DEPTH);
   localparam int FW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (FW > porq_pkg::QUEUED_WIDTH) ? FW : porq_pkg::QUEUED_WIDTH;
   localparam logic [FW-1:0] DEPTH_FULL = FW'(QUEUE_DEPTH);

   typedef struct packed {
      logic [31:0]        frame_handle;
      logic signed [31:0] order_count;
   } entry_type;

   entry_type mem [QUEUE_DEPTH];

   porq_pkg::porq_req_type                req_ff, req_in;
   porq_pkg::porq_rsp_type                rsp_ff, rsp_in;
   logic [porq_pkg::REORDER_WIDTH-1:0]    max_reorder_ff, max_reorder_in;
   logic [FW-1:0]                         fill_ff, fill_in;
   logic [FW-1:0]                         idx_ff, idx_in;
   logic [AW-1:0]                         rd_idx_ff, rd_idx_in;
   logic                                  rd_vld_ff, rd_vld_in;
   entry_type                             rd_data_ff;
   entry_type                             best_ff, best_in;
   logic [AW-1:0]                         best_idx_ff, best_idx_in;

   logic                                  wr_en, rd_en;
   logic [AW-1:0]                         wr_addr, rd_addr;
   entry_type                             wr_data;
   logic                                  idx_live;
   logic [FW-1:0]                         fill_after;
   logic [CMPW-1:0]                       queued_wide;

   assign idx_live = (idx_ff < fill_ff);

   assign status.operation  = req_ff.operation;
   assign status.full       = (fill_ff == DEPTH_FULL);
   assign status.empty      = (fill_ff == '0);
   assign status.over_limit = CMPW'(fill_ff) > CMPW'(max_reorder_ff);
   assign status.scan_done  = !idx_live && !rd_vld_ff;
   assign status.shift_done = !idx_live && !rd_vld_ff;

   assign rsp_payload = rsp_ff;

   always_comb begin
      req_in         = cmd.load_req ? req_payload : req_ff;
      max_reorder_in = csr_write ? csr_data : max_reorder_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      rd_idx_in      = idx_ff[AW-1:0];
      rd_vld_in      = 1'b0;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = fill_ff[AW-1:0];
      wr_data        = '{frame_handle: req_ff.frame_handle, order_count: req_ff.order_count};
      rd_en          = 1'b0;
      rd_addr        = idx_ff[AW-1:0];
      fill_after     = fill_ff;
      queued_wide    = CMPW'(fill_ff);

      if (cmd.push) begin
         wr_en   = 1'b1;
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.clear) begin
         fill_in = '0;
      end

      if (cmd.scan || cmd.shift) begin
         rd_en     = idx_live;
         rd_vld_in = idx_live;
         if (idx_live) begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (cmd.scan && rd_vld_ff) begin
         if (rd_idx_ff == '0 || rd_data_ff.order_count < best_ff.order_count) begin
            best_in     = rd_data_ff;
            best_idx_in = rd_idx_ff;
         end
      end

      if (cmd.shift && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - 1'b1;
         wr_data = rd_data_ff;
      end

      if (cmd.scan_start) begin
         idx_in    = '0;
         rd_vld_in = 1'b0;
      end
      if (cmd.shift_start) begin
         idx_in    = FW'(best_idx_ff) + 1'b1;
         rd_vld_in = 1'b0;
         rd_en     = 1'b0;
      end

      if (cmd.load_rsp) begin
         if (cmd.outcome == porq_pkg::OUT_POPPED) begin
            fill_after            = fill_ff - 1'b1;
            fill_in               = fill_after;
            rsp_in.popped_handle  = best_ff.frame_handle;
            rsp_in.popped_count   = best_ff.order_count;
         end else begin
            rsp_in.popped_handle  = '0;
            rsp_in.popped_count   = '0;
         end
         queued_wide    = CMPW'(fill_after);
         rsp_in.outcome = cmd.outcome;
         rsp_in.queued  = queued_wide[porq_pkg::QUEUED_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         max_reorder_ff <= '0;
         rd_vld_ff      <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         max_reorder_ff <= max_reorder_in;
         rd_vld_ff      <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   `PORQ_ASSERT_ALWAYS(a_fill_bound, reset || fill_ff <= DEPTH_FULL, "fill level above depth")
   `PORQ_ASSERT(a_push_not_full, cmd.push |-> !status.full, "push into full queue")
   `PORQ_ASSERT(a_pop_not_empty, (cmd.load_rsp && cmd.outcome == porq_pkg::OUT_POPPED) |-> !status.empty, "pop from empty queue")

endmodule

[hdl/poc_reorder_output_queue.sv]
// ----------------------------------------------------------------------------
// Reorder output queue (top level)
// Decoded-frame reorder queue: push, bump over limit, flush one, clear.
// ----------------------------------------------------------------------------
// One item is processed at a time and every item yields exactly one result.
// Push, clear, a bump within the limit and a flush of an empty queue go
// from decode straight to finish, with no scan or shift. A pop scans the queued entries
// through the single read port of the entry memory, one entry per cycle,
// then shifts the entries above the removed one down, again one per cycle.
// A finished result waits in the output register while the next item is
// accepted and processed; that item's result is held back until the
// waiting one is taken.
`timescale 1ns / 1ps

module poc_reorder_output_queue #(
   parameter int QUEUE_DEPTH = porq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  porq_pkg::porq_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output porq_pkg::porq_rsp_type              rsp_payload,
   input  logic                                csr_write,
   input  logic [porq_pkg::REORDER_WIDTH-1:0]  csr_data
);

   porq_pkg::porq_cmd_type    cmd;
   porq_pkg::porq_status_type status;

   porq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   porq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

[dv/poc_reorder_output_queue_test.sv]
// ----------------------------------------------------------------------------
// Reorder output queue testbench
// Drives push, bump, flush and clear items through the queue under random
// sender gaps and receiver stalls, across several reorder limits. A
// scoreboard tracks the queued frames and checks every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module poc_reorder_output_queue_test;

   localparam int QUEUE_DEPTH     = porq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int PHASE_COUNT     = 9;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int HOLD_CYCLES     = 400;

   class frame_order_scoreboard;
      logic [31:0]                        slot_handle [QUEUE_DEPTH];
      logic signed [31:0]                 slot_count [QUEUE_DEPTH];
      int                                 fill;
      logic [porq_pkg::REORDER_WIDTH-1:0] reorder_limit;
      porq_pkg::porq_rsp_type             expected_q [$];
      int                                 mismatches;

      function new();
         fill = 0;
         reorder_limit = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // smallest count wins, earliest entry on ties; upper entries shift down
      function porq_pkg::porq_rsp_type pop_smallest();
         porq_pkg::porq_rsp_type r;
         int best;
         best = 0;
         for (int i = 1; i < fill; i++) begin
            if (slot_count[i] < slot_count[best]) best = i;
         end
         r = '0;
         r.outcome = porq_pkg::OUT_POPPED;
         r.popped_handle = slot_handle[best];
         r.popped_count = slot_count[best];
         for (int i = best; i < fill - 1; i++) begin
            slot_handle[i] = slot_handle[i + 1];
            slot_count[i] = slot_count[i + 1];
         end
         fill--;
         return r;
      endfunction

      function void note_request(porq_pkg::porq_req_type item);
         porq_pkg::porq_rsp_type r;
         r = '0;
         case (item.operation)
            porq_pkg::OP_PUSH: begin
               if (fill >= QUEUE_DEPTH) begin
                  r.outcome = porq_pkg::OUT_FULL;
               end else begin
                  slot_handle[fill] = item.frame_handle;
                  slot_count[fill] = item.order_count;
                  fill++;
                  r.outcome = porq_pkg::OUT_DONE;
               end
            end
            porq_pkg::OP_BUMP: begin
               if (fill > reorder_limit) r = pop_smallest();
            end
            porq_pkg::OP_FLUSH: begin
               if (fill == 0) r.outcome = porq_pkg::OUT_EMPTY;
               else r = pop_smallest();
            end
            default: begin
               fill = 0;
            end
         endcase
         r.queued = porq_pkg::QUEUED_WIDTH'(fill);
         expected_q.push_back(r);
      endfunction

      function void check_result(porq_pkg::porq_rsp_type got);
         porq_pkg::porq_rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result outcome %0d handle %h count %0d queued %0d",
                        $time, got.outcome, got.popped_handle, got.popped_count,
                        got.queued);
            return;
         end
         want = expected_q.pop_front();
         if (got.outcome !== want.outcome || got.popped_handle !== want.popped_handle ||
             got.popped_count !== want.popped_count || got.queued !== want.queued) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch expected outcome %0d handle %h count %0d queued %0d",
                        $time, want.outcome, want.popped_handle, want.popped_count,
                        want.queued);
               $display("%0t:            got outcome %0d handle %h count %0d queued %0d",
                        $time, got.outcome, got.popped_handle, got.popped_count,
                        got.queued);
            end
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   porq_pkg::porq_req_type             req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   porq_pkg::porq_rsp_type             rsp_payload;
   logic                               csr_write = 1'b0;
   logic [porq_pkg::REORDER_WIDTH-1:0] csr_data = '0;

   frame_order_scoreboard              sb;
   int                                 send_idle_pct = 0;
   int                                 recv_stall_pct = 0;
   int                                 items_sent = 0;
   int                                 results_seen = 0;
   int                                 hold_left = 0;
   logic [31:0]                        display_base = '0;
   logic [porq_pkg::REORDER_WIDTH-1:0] limit_plan [PHASE_COUNT];

   poc_reorder_output_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write(csr_write),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_payload);
            results_seen++;
            // long hold-off so the queue backs up into the input
            if (results_seen == 300 || results_seen == 1100) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 6)) - 32'd3;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return display_base + 32'($urandom_range(0, 9));
      endcase
   endfunction

   task automatic send_item(input porq_pkg::porq_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic send_op(input logic [1:0] op, input logic [31:0] handle,
                          input logic [31:0] count);
      porq_pkg::porq_req_type item;
      item.operation = op;
      item.frame_handle = handle;
      item.order_count = count;
      send_item(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [porq_pkg::REORDER_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.reorder_limit = value;
   endtask

   task automatic run_burst();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         // decoder-style: push a frame, then bump
         n = $urandom_range(1, 6);
         repeat (n) begin
            display_base = display_base + 32'($urandom_range(1, 4));
            send_op(porq_pkg::OP_PUSH, $urandom,
                    display_base + 32'($urandom_range(0, 6)) - 32'd3);
            send_op(porq_pkg::OP_BUMP, $urandom, $urandom);
         end
      end else if (kind <= 5) begin
         n = $urandom_range(8, 20);
         repeat (n) send_op(porq_pkg::OP_PUSH, $urandom, pick_count());
      end else if (kind <= 7) begin
         n = $urandom_range(1, 18);
         repeat (n) send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);
      end else if (kind == 8) begin
         send_op(porq_pkg::OP_CLEAR, $urandom, $urandom);
         display_base = $urandom;
      end else begin
         n = $urandom_range(1, 5);
         repeat (n) send_op(2'($urandom_range(0, 3)), $urandom, pick_count());
      end
   endtask

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int phase_start;
      bit paused;
      sb = new();
      limit_plan = '{5'd0, 5'd16, 5'd1, 5'd4, 5'd15, 5'd0, 5'd2, 5'd8, 5'd0};
      limit_plan[5] = porq_pkg::REORDER_WIDTH'($urandom_range(0, 16));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset limit of zero, empty cases, extreme counts, ties
      send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);
      send_op(porq_pkg::OP_BUMP, $urandom, $urandom);
      send_op(porq_pkg::OP_CLEAR, $urandom, $urandom);
      send_op(porq_pkg::OP_PUSH, 32'h0000_0000, 32'h7fff_ffff);
      send_op(porq_pkg::OP_PUSH, 32'hffff_ffff, 32'h8000_0000);
      send_op(porq_pkg::OP_PUSH, 32'h0000_0001, 32'd5);
      send_op(porq_pkg::OP_PUSH, 32'h0000_0002, 32'd5);
      send_op(porq_pkg::OP_PUSH, 32'h0000_0003, 32'hffff_ffff);
      send_op(porq_pkg::OP_BUMP, $urandom, $urandom);
      send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);
      send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);
      send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);
      send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);
      send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);
      send_op(porq_pkg::OP_PUSH, 32'h5555_aaaa, 32'd0);
      send_op(porq_pkg::OP_PUSH, 32'haaaa_5555, 32'hffff_fffe);
      send_op(porq_pkg::OP_CLEAR, $urandom, $urandom);
      send_op(porq_pkg::OP_FLUSH, $urandom, $urandom);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 24;
            recv_stall_pct = 85;
         end else if (phase < 6) begin
            send_idle_pct = 85;
            recv_stall_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         wait_drained();
         write_limit(limit_plan[phase]);
         phase_start = items_sent;
         paused = 0;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            run_burst();
            if (!paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
               wait_drained();
               paused = 1;
            end
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
